// ----- rtl/afct_pkg.sv -----
// Shared types and constants for the box versus frustum cull unit.
// Holds the fixed-point widths, box and plane structs, and the register map.
// No dependencies.
package afct_pkg;

  localparam int FRAC_BITS   = 16;
  localparam int COORD_W     = 32;
  localparam int COEF_W      = COORD_W + 1;
  localparam int PROD_W      = COEF_W + COORD_W;
  localparam int DIST_W      = PROD_W + 2;
  localparam int NUM_PLANES  = 6;
  localparam int NUM_ROWS    = 4;
  localparam int NUM_COLS    = 4;
  localparam int CELL_STAGES = 2;
  localparam int PIPE_DEPTH  = NUM_PLANES * CELL_STAGES + 1;

  localparam int NUM_CFG    = 8;
  localparam int CFG_DATA_W = 64;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_SEL_W  = $clog2(NUM_CFG);

  localparam int CFG_ROW_X_01 = 0;
  localparam int CFG_ROW_X_23 = 1;
  localparam int CFG_ROW_Y_01 = 2;
  localparam int CFG_ROW_Y_23 = 3;
  localparam int CFG_ROW_Z_01 = 4;
  localparam int CFG_ROW_Z_23 = 5;
  localparam int CFG_ROW_W_01 = 6;
  localparam int CFG_ROW_W_23 = 7;

  localparam int ROW_X = 0;
  localparam int ROW_Y = 1;
  localparam int ROW_Z = 2;
  localparam int ROW_W = 3;

  localparam logic [CFG_DATA_W-1:0] CFG_ONE_LO = CFG_DATA_W'(1) << FRAC_BITS;
  localparam logic [CFG_DATA_W-1:0] CFG_ONE_HI = CFG_ONE_LO << COORD_W;

  // The reset matrix is the identity.
  localparam logic [CFG_DATA_W-1:0] CFG_RESET [NUM_CFG] = '{
    CFG_ONE_LO, '0, CFG_ONE_HI, '0, '0, CFG_ONE_LO, '0, CFG_ONE_HI
  };

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [COEF_W-1:0]  coef_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic signed [DIST_W-1:0]  dist_t;

  typedef struct packed {
    coord_t min_x;
    coord_t min_y;
    coord_t min_z;
    coord_t max_x;
    coord_t max_y;
    coord_t max_z;
  } box_t;

  typedef struct packed {
    logic valid;
    logic vis;
    box_t box;
  } token_t;

  typedef struct packed {
    coef_t a;
    coef_t b;
    coef_t c;
    coef_t d;
  } plane_t;

  typedef enum logic [2:0] {
    PL_LEFT,
    PL_RIGHT,
    PL_BOTTOM,
    PL_TOP,
    PL_NEAR,
    PL_FAR
  } plane_id_t;

endpackage

// ----- rtl/afct_box_if.sv -----
// Request channel carrying one axis-aligned box.
// Depends on afct_pkg for the coordinate type.
interface afct_box_if import afct_pkg::*; ();
  logic   valid;
  logic   ready;
  coord_t box_min_x;
  coord_t box_min_y;
  coord_t box_min_z;
  coord_t box_max_x;
  coord_t box_max_y;
  coord_t box_max_z;

  modport source (
    output valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    input  ready
  );
  modport sink (
    input  valid, box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z,
    output ready
  );
endinterface

// ----- rtl/afct_vis_if.sv -----
// Result channel carrying the visibility flag of one box.
// No dependencies.
interface afct_vis_if;
  logic valid;
  logic ready;
  logic visible;

  modport source (output valid, visible, input ready);
  modport sink (input valid, visible, output ready);
endinterface

// ----- rtl/afct_coef_regs.sv -----
// Clip matrix registers and the six derived plane coefficient sets.
// Depends on afct_pkg.
module afct_coef_regs import afct_pkg::*; (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [CFG_IDX_W-1:0]          cfg_index,
  input  logic [CFG_DATA_W-1:0]         cfg_wdata,
  output plane_t [NUM_PLANES-1:0]       planes
);

  logic [CFG_DATA_W-1:0]   cfg_r [NUM_CFG];
  coord_t                  m [NUM_ROWS][NUM_COLS];
  coef_t                   col [NUM_COLS];
  plane_t [NUM_PLANES-1:0] planes_nxt;
  plane_t [NUM_PLANES-1:0] planes_r;

  function automatic coef_t combine(plane_id_t p, coord_t x, coord_t y, coord_t z,
                                    coord_t w);
    unique case (p)
      PL_LEFT:   combine = COEF_W'(w) + COEF_W'(x);
      PL_RIGHT:  combine = COEF_W'(w) - COEF_W'(x);
      PL_BOTTOM: combine = COEF_W'(w) + COEF_W'(y);
      PL_TOP:    combine = COEF_W'(w) - COEF_W'(y);
      PL_NEAR:   combine = COEF_W'(z);
      PL_FAR:    combine = COEF_W'(w) - COEF_W'(z);
      default:   combine = '0;
    endcase
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_CFG; i++) begin
        cfg_r[i] <= CFG_RESET[i];
      end
    end else if (cfg_we && (cfg_index < CFG_IDX_W'(NUM_CFG))) begin
      cfg_r[cfg_index[CFG_SEL_W-1:0]] <= cfg_wdata;
    end
  end

  always_comb begin
    for (int r = 0; r < NUM_ROWS; r++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        m[r][c] = cfg_r[2 * r + (c >> 1)][COORD_W * (c & 1) +: COORD_W];
      end
    end
  end

  always_comb begin
    for (int c = 0; c < NUM_COLS; c++) begin
      col[c] = '0;
    end
    for (int p = 0; p < NUM_PLANES; p++) begin
      for (int c = 0; c < NUM_COLS; c++) begin
        col[c] = combine(plane_id_t'(3'(p)), m[ROW_X][c], m[ROW_Y][c], m[ROW_Z][c],
                         m[ROW_W][c]);
      end
      planes_nxt[p] = '{a: col[0], b: col[1], c: col[2], d: col[3]};
    end
  end

  always_ff @(posedge clk) begin
    planes_r <= planes_nxt;
  end

  assign planes = planes_r;

endmodule

// ----- rtl/afct_plane_cell.sv -----
// One cell of the cull chain: tests the passing box against one plane.
// Two register stages: corner products, then distance sum and sign. Uses afct_pkg.
module afct_plane_cell import afct_pkg::*; (
  input  logic   clk,
  input  logic   rst_n,
  input  plane_t plane,
  input  token_t up,
  output logic   up_ready,
  output token_t dn,
  input  logic   dn_ready
);

  logic   a_valid_r;
  logic   a_vis_r;
  box_t   a_box_r;
  prod_t  a_p0_r;
  prod_t  a_p1_r;
  prod_t  a_p2_r;
  coef_t  a_d_r;
  logic   b_valid_r;
  logic   b_vis_r;
  box_t   b_box_r;

  logic   a_ready;
  logic   b_ready;
  coord_t vx;
  coord_t vy;
  coord_t vz;
  prod_t  p0_nxt;
  prod_t  p1_nxt;
  prod_t  p2_nxt;
  dist_t  dist_sum;
  logic   vis_nxt;

  assign b_ready  = !b_valid_r || dn_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign up_ready = a_ready;

  // The positive corner takes the max coordinate where the coefficient is non-negative.
  always_comb begin
    vx     = plane.a[COEF_W-1] ? up.box.min_x : up.box.max_x;
    vy     = plane.b[COEF_W-1] ? up.box.min_y : up.box.max_y;
    vz     = plane.c[COEF_W-1] ? up.box.min_z : up.box.max_z;
    p0_nxt = PROD_W'(plane.a) * PROD_W'(vx);
    p1_nxt = PROD_W'(plane.b) * PROD_W'(vy);
    p2_nxt = PROD_W'(plane.c) * PROD_W'(vz);
  end

  always_comb begin
    dist_sum = DIST_W'(a_p0_r) + DIST_W'(a_p1_r) + DIST_W'(a_p2_r)
             + (DIST_W'(a_d_r) <<< FRAC_BITS);
    vis_nxt  = a_vis_r && !dist_sum[DIST_W-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= up.valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready) begin
      a_vis_r <= up.vis;
      a_box_r <= up.box;
      a_p0_r  <= p0_nxt;
      a_p1_r  <= p1_nxt;
      a_p2_r  <= p2_nxt;
      a_d_r   <= plane.d;
    end
    if (b_ready) begin
      b_vis_r <= vis_nxt;
      b_box_r <= a_box_r;
    end
  end

  assign dn = '{valid: b_valid_r, vis: b_vis_r, box: b_box_r};

endmodule

// ----- rtl/aabb_frustum_cull_test_unit.sv -----
// Box versus clip-space frustum cull unit: a head register and six plane cells.
// A request goes through the head register, then both stages of each plane cell.
// Throughput: one request per cycle when not stalled, via the two-stage plane cells.
// Up to 13 requests are in flight; bubbles close up when the result side stalls.
// Reset (synchronous, active low) empties the chain and loads the identity matrix.
module aabb_frustum_cull_test_unit import afct_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  afct_box_if.sink              in_box,
  afct_vis_if.source            out_res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  plane_t [NUM_PLANES-1:0] planes;
  token_t                  tok [NUM_PLANES+1];
  logic   [NUM_PLANES:0]   rdy;
  logic                    head_valid_r;
  box_t                    head_box_r;
  logic                    head_ready;
  box_t                    box_in;

  afct_coef_regs u_coef (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .planes    (planes)
  );

  assign box_in = '{min_x: in_box.box_min_x, min_y: in_box.box_min_y,
                    min_z: in_box.box_min_z, max_x: in_box.box_max_x,
                    max_y: in_box.box_max_y, max_z: in_box.box_max_z};

  assign head_ready   = !head_valid_r || rdy[0];
  assign in_box.ready = head_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_valid_r <= 1'b0;
    end else if (head_ready) begin
      head_valid_r <= in_box.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (head_ready) begin
      head_box_r <= box_in;
    end
  end

  assign tok[0] = '{valid: head_valid_r, vis: 1'b1, box: head_box_r};

  for (genvar p = 0; p < NUM_PLANES; p++) begin : g_cell
    afct_plane_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .plane    (planes[p]),
      .up       (tok[p]),
      .up_ready (rdy[p]),
      .dn       (tok[p+1]),
      .dn_ready (rdy[p+1])
    );
  end

  assign rdy[NUM_PLANES] = out_res.ready;
  assign out_res.valid   = tok[NUM_PLANES].valid;
  assign out_res.visible = tok[NUM_PLANES].vis;

endmodule

// ----- rtl/afct_checker.sv -----
// Port-level checker for the cull unit, bound to the top level.
// Tracks requests in flight against results delivered. Depends on afct_pkg.
module afct_checker import afct_pkg::*; (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_visible
);

  localparam int CAP   = PIPE_DEPTH;
  localparam int CNT_W = $clog2(CAP + 1);

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic             in_acc;
  logic             out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign cnt_nxt = cnt_r + CNT_W'(in_acc) - CNT_W'(out_acc);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_visible))
    else $error("result changed while stalled");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> cnt_r != '0)
    else $error("result offered with no request in flight");

  a_capacity: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(CAP))
    else $error("more requests in flight than the chain holds");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == '0 |-> in_ready)
    else $error("empty unit refuses a request");

endmodule

bind aabb_frustum_cull_test_unit afct_checker u_afct_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_box.valid),
  .in_ready    (in_box.ready),
  .out_valid   (out_res.valid),
  .out_ready   (out_res.ready),
  .out_visible (out_res.visible)
);

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the box versus clip-space frustum cull unit.
// Needs afct_pkg, afct_box_if, afct_vis_if and aabb_frustum_cull_test_unit from rtl.
module testbench;
  import afct_pkg::*;

  localparam int FX_ONE          = 1 << FRAC_BITS;
  localparam int CFG_IDX_TOP     = (1 << CFG_IDX_W) - 1;
  localparam int BOXES_PER_PHASE = 165;
  localparam int LONG_STALL      = 80;
  localparam int NUM_SETTINGS    = 8;

  typedef logic signed [127:0] dist_acc_t;

  typedef enum int {
    MX_IDENTITY,
    MX_SMALL,
    MX_MOST_NEG,
    MX_MOST_POS,
    MX_ALL_ONES,
    MX_ZERO,
    MX_FULL_RANDOM,
    MX_SPARSE
  } matrix_kind_t;

  class cull_scoreboard;
    logic [CFG_DATA_W-1:0] clip_rows [NUM_CFG];
    bit visible_q [$];
    int unsigned fail_cnt;
    int unsigned boxes_seen;
    int unsigned visible_cnt;
    int unsigned culled_cnt;

    function new();
      foreach (clip_rows[i]) clip_rows[i] = CFG_RESET[i];
      fail_cnt = 0;
      boxes_seen = 0;
      visible_cnt = 0;
      culled_cnt = 0;
    endfunction

    function void write_reg(int unsigned idx, logic [CFG_DATA_W-1:0] val);
      if (idx < NUM_CFG) clip_rows[idx] = val;
    endfunction

    function longint mat_entry(int row, int col);
      logic [CFG_DATA_W-1:0] r;
      r = clip_rows[row * 2 + col / 2];
      return longint'(coord_t'((col % 2) ? r[63:32] : r[31:0]));
    endfunction

    function longint plane_coef(plane_id_t p, int col);
      case (p)
        PL_LEFT:   return mat_entry(ROW_W, col) + mat_entry(ROW_X, col);
        PL_RIGHT:  return mat_entry(ROW_W, col) - mat_entry(ROW_X, col);
        PL_BOTTOM: return mat_entry(ROW_W, col) + mat_entry(ROW_Y, col);
        PL_TOP:    return mat_entry(ROW_W, col) - mat_entry(ROW_Y, col);
        PL_NEAR:   return mat_entry(ROW_Z, col);
        default:   return mat_entry(ROW_W, col) - mat_entry(ROW_Z, col);
      endcase
    endfunction

    // A box survives only if its most positive corner lies on or inside every plane.
    function bit predict_visible(box_t b);
      longint lo [3];
      longint hi [3];
      longint coef [4];
      dist_acc_t acc;
      bit vis;
      vis = 1'b1;
      lo[0] = b.min_x; lo[1] = b.min_y; lo[2] = b.min_z;
      hi[0] = b.max_x; hi[1] = b.max_y; hi[2] = b.max_z;
      for (int p = 0; p < NUM_PLANES; p++) begin
        for (int c = 0; c < NUM_COLS; c++) coef[c] = plane_coef(plane_id_t'(p), c);
        acc = dist_acc_t'(coef[3]) <<< FRAC_BITS;
        for (int k = 0; k < 3; k++) begin
          acc = acc + dist_acc_t'(coef[k]) * dist_acc_t'(coef[k] >= 0 ? hi[k] : lo[k]);
        end
        if (acc < 0) vis = 1'b0;
      end
      return vis;
    endfunction

    function void note_box(box_t b);
      visible_q = {visible_q, predict_visible(b)};
      boxes_seen++;
    endfunction

    function void check_result(logic vis);
      bit exp_vis;
      if (visible_q.size() == 0) begin
        $error("visible: result %0b arrived with no request pending", vis);
        fail_cnt++;
        return;
      end
      exp_vis = visible_q.pop_front();
      if (vis !== exp_vis) begin
        $error("visible: expected %0b, got %0b", exp_vis, vis);
        fail_cnt++;
      end
      if (exp_vis) visible_cnt++;
      else culled_cnt++;
    endfunction

    function int unsigned pending();
      return visible_q.size();
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  int unsigned src_idle_pct = 0;
  int unsigned dst_idle_pct = 0;
  int unsigned stall_req = 0;
  int unsigned in_stall_cycles = 0;

  cull_scoreboard sb;

  afct_box_if box_bus ();
  afct_vis_if vis_bus ();

  aabb_frustum_cull_test_unit u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_box    (box_bus),
    .out_res   (vis_bus),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  initial begin
    int unsigned hold_left;
    hold_left = 0;
    vis_bus.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (stall_req != 0) begin
        hold_left = stall_req;
        stall_req <= 0;
      end
      if (hold_left != 0) begin
        vis_bus.ready <= 1'b0;
        hold_left--;
      end else begin
        vis_bus.ready <= ($urandom_range(99) >= dst_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (vis_bus.valid && vis_bus.ready) sb.check_result(vis_bus.visible);
      if (box_bus.valid && !box_bus.ready) in_stall_cycles++;
    end
  end

  function automatic box_t mk_box(int lx, int ly, int lz, int hx, int hy, int hz);
    box_t b;
    b.min_x = coord_t'(lx); b.min_y = coord_t'(ly); b.min_z = coord_t'(lz);
    b.max_x = coord_t'(hx); b.max_y = coord_t'(hy); b.max_z = coord_t'(hz);
    return b;
  endfunction

  function automatic void rand_span(output coord_t lo, output coord_t hi);
    int a;
    int w;
    a = int'($urandom_range(0, 8 * FX_ONE)) - 4 * FX_ONE;
    if ($urandom_range(3) == 0) a = (int'($urandom_range(0, 6)) - 3) * FX_ONE;
    w = int'($urandom_range(0, 3 * FX_ONE));
    if ($urandom_range(15) == 0) w = 0;
    if ($urandom_range(19) == 0) begin
      lo = coord_t'(a + w);
      hi = coord_t'(a);
    end else begin
      lo = coord_t'(a);
      hi = coord_t'(a + w);
    end
  endfunction

  function automatic box_t rand_box();
    box_t b;
    if ($urandom_range(99) < 15) begin
      b = box_t'({$urandom(), $urandom(), $urandom(), $urandom(), $urandom(), $urandom()});
    end else begin
      rand_span(b.min_x, b.max_x);
      rand_span(b.min_y, b.max_y);
      rand_span(b.min_z, b.max_z);
    end
    return b;
  endfunction

  function automatic coord_t small_entry(bit sparse);
    int unsigned pick;
    pick = $urandom_range(7);
    if (pick < (sparse ? 4 : 1)) return '0;
    if (pick == 7) return coord_t'($urandom_range(1) ? FX_ONE : -FX_ONE);
    return coord_t'(int'($urandom_range(0, 4 * FX_ONE)) - 2 * FX_ONE);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] matrix_reg(matrix_kind_t k, int idx);
    case (k)
      MX_SMALL:       return {small_entry(1'b0), small_entry(1'b0)};
      MX_SPARSE:      return {small_entry(1'b1), small_entry(1'b1)};
      MX_MOST_NEG:    return {2{32'h8000_0000}};
      MX_MOST_POS:    return {2{32'h7FFF_FFFF}};
      MX_ALL_ONES:    return '1;
      MX_ZERO:        return '0;
      MX_FULL_RANDOM: return {$urandom(), $urandom()};
      default:        return CFG_RESET[idx];
    endcase
  endfunction

  task automatic send_box(box_t b);
    while ($urandom_range(99) < src_idle_pct) begin
      box_bus.valid <= 1'b0;
      @(negedge clk);
    end
    box_bus.valid     <= 1'b1;
    box_bus.box_min_x <= b.min_x;
    box_bus.box_min_y <= b.min_y;
    box_bus.box_min_z <= b.min_z;
    box_bus.box_max_x <= b.max_x;
    box_bus.box_max_y <= b.max_y;
    box_bus.box_max_z <= b.max_z;
    @(posedge clk);
    while (!box_bus.ready) @(posedge clk);
    sb.note_box(b);
    @(negedge clk);
  endtask

  task automatic drain();
    box_bus.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic write_cfg(int unsigned idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx[CFG_IDX_W-1:0];
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    sb.write_reg(idx, val);
  endtask

  initial begin
    matrix_kind_t kind;
    sb = new();
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    box_bus.valid = 1'b0;
    box_bus.box_min_x = '0;
    box_bus.box_min_y = '0;
    box_bus.box_min_z = '0;
    box_bus.box_max_x = '0;
    box_bus.box_max_y = '0;
    box_bus.box_max_z = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    src_idle_pct <= 11;
    dst_idle_pct <= 72;
    @(negedge clk);

    // Indexes past the register map must leave the identity matrix untouched.
    write_cfg(NUM_CFG, '1);
    write_cfg(CFG_IDX_TOP, 64'h8000_0000_8000_0000);

    send_box(mk_box(-FX_ONE / 2, -FX_ONE / 2, FX_ONE / 4, FX_ONE / 2, FX_ONE / 2, 3 * FX_ONE / 4));
    send_box(mk_box(-3 * FX_ONE, 0, FX_ONE / 2, -2 * FX_ONE, FX_ONE / 2, FX_ONE / 2));
    send_box(mk_box(2 * FX_ONE, 0, FX_ONE / 2, 3 * FX_ONE, FX_ONE / 2, FX_ONE / 2));
    send_box(mk_box(0, -3 * FX_ONE, FX_ONE / 2, 0, -2 * FX_ONE, FX_ONE / 2));
    send_box(mk_box(0, 2 * FX_ONE, FX_ONE / 2, 0, 3 * FX_ONE, FX_ONE / 2));
    send_box(mk_box(0, 0, -2 * FX_ONE, 0, 0, -FX_ONE));
    send_box(mk_box(0, 0, 2 * FX_ONE, 0, 0, 3 * FX_ONE));
    // A corner lying exactly on a plane keeps the box.
    send_box(mk_box(-2 * FX_ONE, 0, FX_ONE / 2, -FX_ONE, 0, FX_ONE / 2));
    send_box(mk_box(-2 * FX_ONE, 0, FX_ONE / 2, -FX_ONE - 1, 0, FX_ONE / 2));
    send_box(mk_box(0, 0, FX_ONE, 0, 0, FX_ONE));
    send_box(mk_box(0, 0, FX_ONE + 1, 0, 0, FX_ONE + 1));
    // Inverted boxes are used exactly as given.
    send_box(mk_box(FX_ONE / 2, FX_ONE / 2, 3 * FX_ONE / 4, -FX_ONE / 2, -FX_ONE / 2, FX_ONE / 4));
    send_box(mk_box(3 * FX_ONE, 0, 0, -3 * FX_ONE, 0, FX_ONE));
    send_box(mk_box(0, 0, 0, 0, 0, 0));
    send_box(mk_box(-1, -1, -1, -1, -1, -1));

    for (int phase = 0; phase < NUM_SETTINGS; phase++) begin
      kind = matrix_kind_t'(phase);
      drain();
      if (phase == 3) begin
        src_idle_pct <= 72;
        dst_idle_pct <= 11;
      end
      if (phase == 6) begin
        src_idle_pct <= 0;
        dst_idle_pct <= 0;
      end
      if (kind != MX_IDENTITY) begin
        for (int idx = 0; idx < NUM_CFG; idx++) write_cfg(idx, matrix_reg(kind, idx));
      end
      if (phase == 6) stall_req <= LONG_STALL;
      send_box(box_t'({6{32'h8000_0000}}));
      send_box(box_t'({6{32'h7FFF_FFFF}}));
      send_box(box_t'({{3{32'h8000_0000}}, {3{32'h7FFF_FFFF}}}));
      repeat (BOXES_PER_PHASE) send_box(rand_box());
    end

    drain();
    repeat (PIPE_DEPTH + 4) @(posedge clk);

    $display("Checked %0d boxes over %0d clip matrices: %0d visible, %0d culled.",
             sb.boxes_seen, NUM_SETTINGS, sb.visible_cnt, sb.culled_cnt);
    $display("Input side was held off for %0d cycles in total.", in_stall_cycles);
    if (sb.fail_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
